// ===== hdl/klt_pkg.sv =====
// Shared types and constants for the keyframe interpolation table.
`timescale 1ns / 1ps
package klt_pkg;
  localparam int TABLE_DEPTH = 64;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int FRAC_W = 16;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CM_HOLD   = 2'd0,
    CM_ROTATE = 2'd1,
    CM_INSERT = 2'd2,
    CM_RSVD   = 2'd3
  } cell_mode_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic [2:0][31:0]   val;
  } entry_t;

  typedef struct packed {
    cell_mode_t mode;
    entry_t     ent;
    logic       eq_any;
    logic       full;
  } cell_ctrl_t;
endpackage

// ===== hdl/klt_cell.sv =====
// One keyframe slot of the table chain.
`timescale 1ns / 1ps
module klt_cell (
  input  logic                clk,
  input  klt_pkg::cell_ctrl_t ctrl,
  input  logic                occ,
  input  klt_pkg::entry_t     left_ent,
  input  logic                left_lt,
  input  klt_pkg::entry_t     right_ent,
  output klt_pkg::entry_t     ent,
  output logic                lt,
  output logic                eq
);
  assign lt = occ && (ent.key < ctrl.ent.key);
  assign eq = occ && (ent.key == ctrl.ent.key);

  always_ff @(posedge clk) begin
    unique case (ctrl.mode)
      klt_pkg::CM_ROTATE: ent <= right_ent;
      klt_pkg::CM_INSERT: begin
        if (ctrl.eq_any) begin
          if (eq) ent.val <= ctrl.ent.val;
        end else if (!ctrl.full && !lt) begin
          // The first slot not below the new key takes it; later slots shift up.
          ent <= left_lt ? ctrl.ent : left_ent;
        end
      end
      default: ent <= ent;
    endcase
  end
endmodule

// ===== hdl/klt_div.sv =====
// Restoring divider that forms the Q0.16 blend factor one bit per cycle.
`timescale 1ns / 1ps
module klt_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [32:0] dx,
  input  logic [32:0] dt,
  output logic [15:0] quo,
  output logic        done
);
  logic [33:0] rem;
  logic [32:0] div;
  logic [4:0]  cnt;
  logic        busy;
  logic [33:0] rem_sh;

  assign rem_sh = {rem[32:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= {1'b0, dx};
        div  <= dt;
        cnt  <= '0;
        quo  <= '0;
      end else if (busy) begin
        if (rem_sh >= {1'b0, div}) begin
          rem <= rem_sh - {1'b0, div};
          quo <= {quo[14:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[14:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== hdl/keyframe_lerp_table_unit.sv =====
// Top level: keyframe table chain, scan sequencer, divider and blend datapath.
//
//   channel  direction  handshake            payload
//   input    in         in_valid/in_ready    opcode, key_time, in_intensity/azimuth/zenith
//   output   out        out_valid/out_ready  out_intensity/azimuth/zenith, status
//
// Clear, insert and the unused opcode act on the table when accepted, then
// the output register is loaded from S_OUT. A query on a non-empty table rotates
// the cell chain through all TABLE_DEPTH slots; when the key falls between two
// keyframes it then runs a divide and six multiply-add steps. Reset is
// synchronous and empties the table; slot contents are left as they are. A
// stalled output holds the finished transaction while the next one waits at the input.
`timescale 1ns / 1ps
module keyframe_lerp_table_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic signed [31:0] key_time,
  input  logic signed [31:0] in_intensity,
  input  logic signed [31:0] in_azimuth,
  input  logic signed [31:0] in_zenith,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_intensity,
  output logic signed [31:0] out_azimuth,
  output logic signed [31:0] out_zenith,
  output logic [1:0]         status
);
  localparam int D = klt_pkg::TABLE_DEPTH;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_PICK, S_DIV, S_MUL, S_OUT} state_t;

  state_t                    state;
  logic [klt_pkg::CNT_W-1:0] count;
  logic [klt_pkg::IDX_W-1:0] k;
  logic signed [31:0]        qkey;
  logic                      found;
  logic                      interp;
  klt_pkg::entry_t           prev;
  klt_pkg::entry_t           lpair;
  klt_pkg::entry_t           rpair;
  logic [2:0][31:0]          res_val;
  klt_pkg::status_t          res_st;
  logic [15:0]               fac;
  logic [2:0]                step;
  logic signed [49:0]        acc;

  klt_pkg::cell_ctrl_t       ctrl;
  klt_pkg::entry_t           cell_ent [D];
  logic [D-1:0]              cell_lt;
  logic [D-1:0]              cell_eq;
  logic                      accept;
  logic                      full;
  logic                      in_range;
  klt_pkg::entry_t           head;
  logic                      div_start;
  logic                      div_done;
  logic [15:0]               div_q;
  logic [32:0]               dx;
  logic [32:0]               dt;
  logic [1:0]                ch;
  logic [16:0]               wgt;
  logic signed [31:0]        mval;
  logic signed [49:0]        prod;
  logic signed [49:0]        sum;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign full     = (count == klt_pkg::CNT_W'(D));
  assign head     = cell_ent[0];
  assign in_range = ({1'b0, k} < count);

  always_comb begin
    ctrl.mode    = klt_pkg::CM_HOLD;
    if (accept && opcode == klt_pkg::OP_INSERT) ctrl.mode = klt_pkg::CM_INSERT;
    else if (state == S_SCAN) ctrl.mode = klt_pkg::CM_ROTATE;
    ctrl.ent.key = key_time;
    ctrl.ent.val = {in_zenith, in_azimuth, in_intensity};
    ctrl.eq_any  = |cell_eq;
    ctrl.full    = full;
  end

  // Each slot sees its left neighbor for inserting and its right neighbor
  // for rotation; the last slot wraps to the first so a full scan restores order.
  for (genvar i = 0; i < D; i++) begin : g_cell
    klt_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occ       (klt_pkg::CNT_W'(i) < count),
      .left_ent  ((i == 0) ? cell_ent[0] : cell_ent[(i + D - 1) % D]),
      .left_lt   ((i == 0) ? 1'b1 : cell_lt[(i + D - 1) % D]),
      .right_ent (cell_ent[(i + 1) % D]),
      .ent       (cell_ent[i]),
      .lt        (cell_lt[i]),
      .eq        (cell_eq[i])
    );
  end

  assign dx = {qkey[31], qkey} - {lpair.key[31], lpair.key};
  assign dt = {rpair.key[31], rpair.key} - {lpair.key[31], lpair.key};
  assign div_start = (state == S_PICK) && found && interp;

  klt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .dx    (dx),
    .dt    (dt),
    .quo   (div_q),
    .done  (div_done)
  );

  // Even steps weight the left keyframe by one minus the factor, odd steps
  // add the right keyframe weighted by the factor.
  assign ch   = step[2:1];
  assign wgt  = step[0] ? {1'b0, fac} : 17'(17'h10000 - {1'b0, fac});
  assign mval = step[0] ? $signed(rpair.val[ch]) : $signed(lpair.val[ch]);
  assign prod = 50'(mval * $signed({1'b0, wgt}));
  assign sum  = (step[0] ? acc : 50'sd0) + prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      found     <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            qkey    <= key_time;
            res_val <= '0;
            res_st  <= klt_pkg::ST_OK;
            found   <= 1'b0;
            k       <= '0;
            state   <= S_OUT;
            if (opcode == klt_pkg::OP_CLEAR) begin
              count <= '0;
            end else if (opcode == klt_pkg::OP_INSERT) begin
              if (!ctrl.eq_any) begin
                if (full) res_st <= klt_pkg::ST_FULL;
                else count <= count + 1'b1;
              end
            end else if (opcode == klt_pkg::OP_QUERY) begin
              if (count == '0) res_st <= klt_pkg::ST_EMPTY;
              else state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (in_range && !found) begin
            if (k == '0 && qkey <= head.key) begin
              res_val <= head.val;
              found   <= 1'b1;
              interp  <= 1'b0;
            end else if (k != '0 && qkey < head.key) begin
              lpair  <= prev;
              rpair  <= head;
              found  <= 1'b1;
              interp <= 1'b1;
            end
          end
          if (in_range) prev <= head;
          k <= k + 1'b1;
          if (k == klt_pkg::IDX_W'(D - 1)) state <= S_PICK;
        end
        S_PICK: begin
          if (!found) begin
            res_val <= prev.val;
            state   <= S_OUT;
          end else if (interp) begin
            state <= S_DIV;
          end else begin
            state <= S_OUT;
          end
        end
        S_DIV: begin
          if (div_done) begin
            fac   <= div_q;
            step  <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          acc <= sum;
          if (step[0]) res_val[ch] <= sum[47:16];
          step <= step + 3'd1;
          if (step == 3'd5) state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_intensity <= res_val[0];
            out_azimuth   <= res_val[1];
            out_zenith    <= res_val[2];
            status        <= res_st;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= klt_pkg::CNT_W'(D))
    else $error("entry count above table depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    accept && opcode == klt_pkg::OP_CLEAR |=> count == '0)
    else $error("clear did not empty the table");

  a_div_only_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside divide state");

  a_full_reject: assert property (@(posedge clk) disable iff (rst)
    accept && opcode == klt_pkg::OP_INSERT && full && !ctrl.eq_any |=> count == $past(count))
    else $error("insert into full table changed the count");
endmodule
